// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the glyph row blitter modules
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define SGRB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SGRB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sgrb_pkg.sv =====
// shared constants, types and colour helper for the glyph row blitter
// no dependencies
`timescale 1ns / 1ps

package sgrb_pkg;

  // sizing
  localparam int MAX_SCALE_W = 16;
  localparam int MAX_SCALE_H = 8;
  localparam int OFFSET_BITS = 24;
  localparam int SUB_W       = (MAX_SCALE_H > 1) ? $clog2(MAX_SCALE_H) : 1;
  localparam int LINE_W      = 13;

  // configuration register indexes
  localparam logic [2:0] REG_WIDE_PIXELS = 3'd0;
  localparam logic [2:0] REG_LINE_STRIDE = 3'd1;
  localparam logic [2:0] REG_SCALE_W     = 3'd2;
  localparam logic [2:0] REG_SCALE_H     = 3'd3;
  localparam logic [2:0] REG_FORE_COLOUR = 3'd4;
  localparam logic [2:0] REG_BACK_COLOUR = 3'd5;

  // effective configuration seen by the datapath
  typedef struct packed {
    logic        wide;
    logic [15:0] stride;
    logic [4:0]  w_eff;
    logic [SUB_W-1:0] hm1;
    logic [15:0] fg;
    logic [15:0] bg;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic setup;
    logic load;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;
    logic final_run;
  } sts_t;

  // rgb565 to output pixel word
  function automatic logic [31:0] expand_pixel(input logic [15:0] c, input logic wide);
    logic [31:0] res;
    if (wide) begin
      res = {8'hFF, c[15:11], 3'b000, c[10:5], 2'b00, c[4:0], 3'b000};
    end else begin
      res = {16'h0000, c};
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/sgrb_in_if.sv =====
// input channel: one glyph row per transaction
// depends on nothing
`timescale 1ns / 1ps

interface sgrb_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  glyph_bits;
  logic [11:0] origin_x;
  logic [11:0] origin_y;
  logic [2:0]  row_number;

  modport source (output valid, glyph_bits, origin_x, origin_y, row_number, input ready);
  modport sink (input valid, glyph_bits, origin_x, origin_y, row_number, output ready);
endinterface

// ===== rtl/core/sgrb_out_if.sv =====
// result channel: one pixel run per transaction
// depends on nothing
`timescale 1ns / 1ps

interface sgrb_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] byte_offset;
  logic [4:0]  run_pixels;
  logic [31:0] pixel_value;
  logic        last;

  modport source (output valid, byte_offset, run_pixels, pixel_value, last, input ready);
  modport sink (input valid, byte_offset, run_pixels, pixel_value, last, output ready);
endinterface

// ===== rtl/core/sgrb_ctrl.sv =====
// sequencing state machine for the glyph row blitter
// depends on sgrb_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sgrb_ctrl
  import sgrb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_LOAD  = 4'b0100,
    ST_RUN   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // command decode
  always_comb begin
    in_ready    = (state_r == ST_IDLE);
    cmd.capture = (state_r == ST_IDLE) && in_valid;
    cmd.setup   = (state_r == ST_SETUP);
    cmd.load    = (state_r == ST_LOAD);
    cmd.emit    = (state_r == ST_RUN) && sts.slot_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SETUP;
      end
      ST_SETUP: state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_RUN;
      ST_RUN: begin
        if (sts.slot_free && sts.final_run) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `SGRB_ASSERT_NXT(a_capture_to_setup, cmd.capture, state_r == ST_SETUP, "capture not followed by setup")
  `SGRB_ASSERT_NXT(a_final_to_idle, cmd.emit && sts.final_run, state_r == ST_IDLE, "final run did not end item")
  `SGRB_ASSERT_IMP(a_single_cmd, 1'b1, $onehot0({cmd.capture, cmd.setup, cmd.load, cmd.emit}), "overlapping commands")

endmodule

// ===== rtl/core/sgrb_dpath.sv =====
// offset, counter and output register datapath for the glyph row blitter
// depends on sgrb_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sgrb_dpath
  import sgrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [7:0]  in_glyph_bits,
  input  logic [11:0] in_origin_x,
  input  logic [11:0] in_origin_y,
  input  logic [2:0]  in_row_number,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [23:0] out_byte_offset,
  output logic [4:0]  out_run_pixels,
  output logic [31:0] out_pixel_value,
  output logic        out_last
);

  logic [7:0]             glyph_r;
  logic [11:0]            ox_r;
  logic [LINE_W-1:0]      line_r;
  logic [OFFSET_BITS-1:0] prod_r, xofs_r, col_r, cur_r;
  logic [2:0]             bit_r;
  logic [SUB_W-1:0]       sub_r;
  logic                   out_valid_r;
  logic [23:0]            ofs_out_r;
  logic [4:0]             run_out_r;
  logic [31:0]            pix_out_r;
  logic                   last_out_r;

  logic [7:0]             row_h;
  logic [6:0]             wstep;
  logic [OFFSET_BITS-1:0] col_step;
  logic                   sub_end;

  always_comb begin
    row_h    = {5'd0, in_row_number} * {4'd0, ({1'b0, cfg.hm1} + 4'd1)};
    wstep    = cfg.wide ? {cfg.w_eff, 2'b00} : {1'b0, cfg.w_eff, 1'b0};
    col_step = col_r + OFFSET_BITS'(wstep);
    sub_end  = (sub_r == cfg.hm1);
    sts.slot_free = !out_valid_r || out_ready;
    sts.final_run = (bit_r == 3'd7) && sub_end;
  end

  // item registers and run walk
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      glyph_r <= in_glyph_bits;
      ox_r    <= in_origin_x;
      line_r  <= LINE_W'(in_origin_y) + LINE_W'(row_h);
    end
    if (cmd.setup) begin
      prod_r <= OFFSET_BITS'(32'(line_r) * 32'(cfg.stride));
      xofs_r <= cfg.wide ? OFFSET_BITS'({ox_r, 2'b00}) : OFFSET_BITS'({ox_r, 1'b0});
    end
    if (cmd.load) begin
      col_r <= prod_r + xofs_r;
      cur_r <= prod_r + xofs_r;
    end
    if (cmd.emit) begin
      if (sub_end) begin
        col_r   <= col_step;
        cur_r   <= col_step;
        glyph_r <= {glyph_r[6:0], 1'b0};
      end else begin
        cur_r <= cur_r + OFFSET_BITS'(cfg.stride);
      end
    end
  end

  // bit and sub-line counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= '0;
      sub_r <= '0;
    end else if (cmd.load) begin
      bit_r <= '0;
      sub_r <= '0;
    end else if (cmd.emit) begin
      if (sub_end) begin
        sub_r <= '0;
        bit_r <= bit_r + 3'd1;
      end else begin
        sub_r <= sub_r + SUB_W'(1);
      end
    end
  end

  // output register, one run per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ofs_out_r  <= 24'(cur_r);
      run_out_r  <= cfg.w_eff;
      pix_out_r  <= expand_pixel(glyph_r[7] ? cfg.fg : cfg.bg, cfg.wide);
      last_out_r <= sts.final_run;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte_offset = ofs_out_r;
  assign out_run_pixels  = run_out_r;
  assign out_pixel_value = pix_out_r;
  assign out_last        = last_out_r;

  `SGRB_ASSERT_NXT(a_emit_fills_slot, cmd.emit, out_valid_r, "emitted run not presented")
  `SGRB_ASSERT_NXT(a_last_tracks_final, cmd.emit && sts.final_run, last_out_r, "final run not flagged")
  `SGRB_ASSERT_IMP(a_emit_needs_slot, cmd.emit, !out_valid_r || out_ready, "run overwrote waiting transaction")

endmodule

// ===== rtl/core/scaled_glyph_row_blitter_unit.sv =====
// top level of the scaled glyph row blitter: configuration registers,
// controller and datapath; depends on sgrb_pkg, the channel interfaces,
// sgrb_ctrl and sgrb_dpath
//
//   channel  dir  handshake      payload
//   in_if    in   valid/ready    glyph_bits, origin_x, origin_y, row_number
//   out_if   out  valid/ready    byte_offset, run_pixels, pixel_value, last
//   cfg_*    in   cfg_we only    cfg_index, cfg_wdata
//
// an item goes through the setup and load states, then 8 * scale_h runs,
// one per cycle while the single output register is free; it paces the runs
// a new item is taken only once the previous item's last run is registered
// reset is synchronous and active low; it clears control and config registers
`timescale 1ns / 1ps

module scaled_glyph_row_blitter_unit
  import sgrb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  sgrb_in_if.sink      in_if,
  sgrb_out_if.source   out_if,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);

  logic        wide_r;
  logic [15:0] stride_r;
  logic [4:0]  scale_w_r;
  logic [3:0]  scale_h_r;
  logic [15:0] fg_r;
  logic [15:0] bg_r;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // configuration register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r    <= 1'b0;
      stride_r  <= 16'h0000;
      scale_w_r <= 5'd1;
      scale_h_r <= 4'd1;
      fg_r      <= 16'hFFFF;
      bg_r      <= 16'h0000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDE_PIXELS: wide_r    <= cfg_wdata[0];
        REG_LINE_STRIDE: stride_r  <= cfg_wdata;
        REG_SCALE_W:     scale_w_r <= cfg_wdata[4:0];
        REG_SCALE_H:     scale_h_r <= cfg_wdata[3:0];
        REG_FORE_COLOUR: fg_r      <= cfg_wdata;
        REG_BACK_COLOUR: bg_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamp scales to their legal ranges
  always_comb begin
    cfg.wide   = wide_r;
    cfg.stride = stride_r;
    cfg.fg     = fg_r;
    cfg.bg     = bg_r;
    if (scale_w_r == 5'd0) begin
      cfg.w_eff = 5'd1;
    end else if (32'(scale_w_r) > MAX_SCALE_W) begin
      cfg.w_eff = 5'(MAX_SCALE_W);
    end else begin
      cfg.w_eff = scale_w_r;
    end
    if (scale_h_r == 4'd0) begin
      cfg.hm1 = '0;
    end else if (32'(scale_h_r) > MAX_SCALE_H) begin
      cfg.hm1 = SUB_W'(MAX_SCALE_H - 1);
    end else begin
      cfg.hm1 = SUB_W'(scale_h_r - 4'd1);
    end
  end

  sgrb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sgrb_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .cmd             (cmd),
    .sts             (sts),
    .in_glyph_bits   (in_if.glyph_bits),
    .in_origin_x     (in_if.origin_x),
    .in_origin_y     (in_if.origin_y),
    .in_row_number   (in_if.row_number),
    .out_ready       (out_if.ready),
    .out_valid       (out_if.valid),
    .out_byte_offset (out_if.byte_offset),
    .out_run_pixels  (out_if.run_pixels),
    .out_pixel_value (out_if.pixel_value),
    .out_last        (out_if.last)
  );

endmodule

// ===== tb/sv/tb_scaled_glyph_row_blitter_unit.sv =====
`timescale 1ns / 1ps

// self-checking testbench for scaled_glyph_row_blitter_unit: glyph rows in, pixel runs out
// depends on sgrb_pkg, sgrb_in_if, sgrb_out_if and the unit under test

module tb_scaled_glyph_row_blitter_unit;
  import sgrb_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 100;
  localparam int RANDOM_ROWS     = 170;
  localparam int ROWS_PER_PHASE  = 17;
  localparam int STEADY_PHASE    = 3;

  // indexes with no register behind them
  localparam logic [2:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;

  typedef struct packed {
    logic [7:0]  glyph_bits;
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [2:0]  row_number;
  } glyph_row_t;

  typedef struct packed {
    logic [23:0] byte_offset;
    logic [4:0]  run_pixels;
    logic [31:0] pixel_value;
    logic        last;
  } pixel_run_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  sgrb_in_if  in_bus ();
  sgrb_out_if out_bus ();

  scaled_glyph_row_blitter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_bus),
    .out_if    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow copy of the configuration registers
  logic        shadow_wide;
  logic [15:0] shadow_stride;
  logic [4:0]  shadow_scale_w;
  logic [3:0]  shadow_scale_h;
  logic [15:0] shadow_fore;
  logic [15:0] shadow_back;

  pixel_run_t expected_runs[$];

  int fail_count    = 0;
  int rows_sent     = 0;
  int runs_checked  = 0;
  int settings_used = 0;
  int idle_cycles   = 0;
  bit steady        = 1'b0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones, none in a steady stretch
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic glyph_row_t make_row(input logic [7:0] bits, input logic [11:0] x,
                                          input logic [11:0] y, input logic [2:0] r);
    glyph_row_t row;
    row.glyph_bits = bits;
    row.origin_x   = x;
    row.origin_y   = y;
    row.row_number = r;
    return row;
  endfunction

  // rgb565 to the word carried on the result channel
  function automatic logic [31:0] pixel_word(input logic [15:0] c565, input logic wide);
    logic [7:0] red8, green8, blue8;
    red8   = {c565[15:11], 3'b000};
    green8 = {c565[10:5], 2'b00};
    blue8  = {c565[4:0], 3'b000};
    if (!wide) return {16'h0000, c565};
    return {8'hFF, red8, green8, blue8};
  endfunction

  // expected runs of one glyph row: column by column, sub-lines top to bottom
  task automatic expand_glyph_row(input glyph_row_t row);
    int unsigned w_eff, h_eff, bpp, total, n;
    longint unsigned px, ln, ofs;
    logic [31:0] fore_word, back_word;
    pixel_run_t run;
    if (shadow_scale_w == 0) w_eff = 1;
    else if (shadow_scale_w > MAX_SCALE_W) w_eff = MAX_SCALE_W;
    else w_eff = 32'(shadow_scale_w);
    if (shadow_scale_h == 0) h_eff = 1;
    else if (shadow_scale_h > MAX_SCALE_H) h_eff = MAX_SCALE_H;
    else h_eff = 32'(shadow_scale_h);
    bpp       = shadow_wide ? 4 : 2;
    fore_word = pixel_word(shadow_fore, shadow_wide);
    back_word = pixel_word(shadow_back, shadow_wide);
    total     = 8 * h_eff;
    n         = 0;
    for (int col = 0; col < 8; col++) begin
      px = longint'(row.origin_x) + col * w_eff;
      for (int sub = 0; sub < h_eff; sub++) begin
        ln  = longint'(row.origin_y) + row.row_number * h_eff + sub;
        ofs = (px * bpp + ln * shadow_stride) & ((64'd1 << OFFSET_BITS) - 1);
        n++;
        run.byte_offset = ofs[23:0];
        run.run_pixels  = w_eff[4:0];
        run.pixel_value = row.glyph_bits[7 - col] ? fore_word : back_word;
        run.last        = (n == total);
        expected_runs.push_back(run);
      end
    end
  endtask

  // one input transaction, with valid low between it and the previous one
  task automatic send_row(input glyph_row_t row);
    int gap;
    gap = pick_gap();
    @(posedge clk);
    repeat (gap) @(posedge clk);
    in_bus.valid      <= 1'b1;
    in_bus.glyph_bits <= row.glyph_bits;
    in_bus.origin_x   <= row.origin_x;
    in_bus.origin_y   <= row.origin_y;
    in_bus.row_number <= row.row_number;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    in_bus.valid <= 1'b0;
    expand_glyph_row(row);
    rows_sent++;
  endtask

  // block is idle once every run has come out and a settling delay has passed
  task automatic wait_idle();
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write; the caller lowers cfg_we after the last one
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_WIDE_PIXELS: shadow_wide    = data[0];
      REG_LINE_STRIDE: shadow_stride  = data;
      REG_SCALE_W:     shadow_scale_w = data[4:0];
      REG_SCALE_H:     shadow_scale_h = data[3:0];
      REG_FORE_COLOUR: shadow_fore    = data;
      REG_BACK_COLOUR: shadow_back    = data;
      default: begin
      end
    endcase
  endtask

  task automatic load_settings(input logic [15:0] wide, input logic [15:0] stride,
                               input logic [15:0] sw, input logic [15:0] sh,
                               input logic [15:0] fore, input logic [15:0] back);
    wait_idle();
    write_reg(REG_WIDE_PIXELS, wide);
    write_reg(REG_LINE_STRIDE, stride);
    write_reg(REG_SCALE_W, sw);
    write_reg(REG_SCALE_H, sh);
    write_reg(REG_FORE_COLOUR, fore);
    write_reg(REG_BACK_COLOUR, back);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // result side back-pressure
  initial begin : ready_gen
    int stall_left;
    stall_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // compare each result transaction with the oldest expected run
  always @(posedge clk) begin : run_checker
    pixel_run_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_runs.size() == 0) begin
        $error("run with nothing expected: byte_offset 0x%0h", out_bus.byte_offset);
        fail_count++;
      end else begin
        want = expected_runs.pop_front();
        compare_field("byte_offset", 32'(want.byte_offset), 32'(out_bus.byte_offset));
        compare_field("run_pixels", 32'(want.run_pixels), 32'(out_bus.run_pixels));
        compare_field("pixel_value", want.pixel_value, out_bus.pixel_value);
        compare_field("last", 32'(want.last), 32'(out_bus.last));
        runs_checked++;
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_scaled_glyph_row_blitter_unit failed");
      $finish;
    end
  end

  // reset values: unit scale, zero stride, 16-bit pixels, white on black
  task automatic test_reset_values();
    send_row(make_row(8'h00, 12'd0, 12'd0, 3'd0));
    send_row(make_row(8'hFF, 12'hFFF, 12'hFFF, 3'd7));
    send_row(make_row(8'hA5, 12'hA5A, 12'h5A5, 3'd3));
    send_row(make_row(8'h5A, 12'h5A5, 12'hA5A, 3'd4));
  endtask

  // zero, exact-maximum and oversized scales with wrapping offsets
  task automatic test_scale_limits();
    load_settings(16'h0001, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
    send_row(make_row(8'h81, 12'hFFF, 12'hFFF, 3'd7));
    send_row(make_row(8'h7E, 12'h000, 12'hFFF, 3'd0));
    load_settings(16'h0000, 16'hFFFF, 16'h001F, 16'h000F, 16'hF800, 16'h07E0);
    send_row(make_row(8'hC3, 12'hFFF, 12'hFFF, 3'd7));
    send_row(make_row(8'h3C, 12'h800, 12'h001, 3'd1));
    load_settings(16'h0001, 16'h8001, 16'd16, 16'd8, 16'h001F, 16'hFFFF);
    send_row(make_row(8'hF0, 12'hFFF, 12'h000, 3'd7));
    send_row(make_row(8'h0F, 12'h123, 12'hFFF, 3'd2));
    load_settings(16'h0000, 16'h0001, 16'd17, 16'd9, 16'h1234, 16'hEDCB);
    send_row(make_row(8'h99, 12'hFFF, 12'hFFF, 3'd5));
  endtask

  // both pixel formats with primary, full and empty colours
  task automatic test_colour_modes();
    load_settings(16'h0000, 16'd640, 16'd2, 16'd1, 16'hFFFF, 16'h0000);
    send_row(make_row(8'h55, 12'd100, 12'd50, 3'd6));
    send_row(make_row(8'hAA, 12'd100, 12'd50, 3'd7));
    load_settings(16'h0001, 16'd2560, 16'd3, 16'd2, 16'hF800, 16'h001F);
    send_row(make_row(8'h55, 12'd8, 12'd16, 3'd1));
    send_row(make_row(8'hAA, 12'd8, 12'd16, 3'd2));
    load_settings(16'h0001, 16'd4096, 16'd1, 16'd3, 16'h07E0, 16'hFFFF);
    send_row(make_row(8'h96, 12'd4000, 12'd4000, 3'd4));
    load_settings(16'h0000, 16'd1024, 16'd4, 16'd1, 16'h0000, 16'hFFFF);
    send_row(make_row(8'h69, 12'd37, 12'd91, 3'd0));
  endtask

  // writes to unmapped indexes must leave the settings alone
  task automatic test_unmapped_index();
    wait_idle();
    write_reg(REG_UNMAPPED_LO, 16'hFFFF);
    write_reg(REG_UNMAPPED_HI, 16'h5A5A);
    write_reg(REG_UNMAPPED_HI, 16'h0000);
    cfg_we <= 1'b0;
    send_row(make_row(8'hE7, 12'd255, 12'd511, 3'd3));
    send_row(make_row(8'h18, 12'd4095, 12'd0, 3'd7));
  endtask

  // random settings per phase, random rows within each phase
  task automatic test_random_rows();
    logic [15:0] stride, sw, sh;
    logic [11:0] ox, oy;
    int phase;
    phase = 0;
    while (rows_sent < RANDOM_ROWS) begin
      case ($urandom_range(0, 3))
        0:       stride = 16'h0000;
        1:       stride = 16'hFFFF;
        default: stride = 16'($urandom);
      endcase
      sw = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 16));
      sh = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 8));
      load_settings(16'($urandom), stride, sw, sh, 16'($urandom), 16'($urandom));
      steady = (phase == STEADY_PHASE);
      for (int i = 0; i < ROWS_PER_PHASE; i++) begin
        ox = ($urandom_range(0, 7) == 0) ? 12'hFFF : 12'($urandom);
        oy = ($urandom_range(0, 7) == 0) ? 12'hFFF : 12'($urandom);
        send_row(make_row(8'($urandom), ox, oy, 3'($urandom)));
      end
      steady = 1'b0;
      phase++;
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_wdata         <= '0;
    in_bus.valid      <= 1'b0;
    in_bus.glyph_bits <= '0;
    in_bus.origin_x   <= '0;
    in_bus.origin_y   <= '0;
    in_bus.row_number <= '0;
    shadow_wide    = 1'b0;
    shadow_stride  = 16'h0000;
    shadow_scale_w = 5'd1;
    shadow_scale_h = 4'd1;
    shadow_fore    = 16'hFFFF;
    shadow_back    = 16'h0000;
    settings_used  = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_scale_limits();
    test_colour_modes();
    test_unmapped_index();
    test_random_rows();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d glyph rows sent, %0d pixel runs checked", rows_sent, runs_checked);
    $display("%0d register settings, both pixel formats, zero and saturated scales",
             settings_used);
    if (fail_count == 0 && expected_runs.size() == 0) begin
      $display("tb_scaled_glyph_row_blitter_unit passed");
    end else begin
      $display("tb_scaled_glyph_row_blitter_unit failed");
    end
    $finish;
  end

endmodule
